### hw/rtl/fwc_pkg.sv
// fwc_pkg: shared constants and types of the frontier window counter
// no dependencies; imported by the top level and by the checker
`default_nettype none

package fwc_pkg;

  // signed coordinate width, covers centre +/- half window and the grid limits
  localparam int CRD_W = 14;

  // cell value and count widths
  localparam int CELL_W = 8;
  localparam int CNT_W  = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // register widths
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int WIN_REG_W = 7;

  // cell value codes
  localparam logic [CELL_W-1:0] UNKNOWN_CELL = 8'hFF;
  localparam logic [CELL_W-1:0] FREE_LIMIT   = 8'd15;

  // smallest grid side in use
  localparam int GRID_MIN = 3;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

### hw/rtl/fwc_ram.sv
// fwc_ram: generic single write port, dual read port ram with registered reads
// no dependencies
`default_nettype none

module fwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

### hw/rtl/frontier_window_counter.sv
// frontier_window_counter: occupancy grid store with frontier counting window
// depends on fwc_pkg and fwc_ram
//
//   channel   | handshake          | payload
//   ----------+--------------------+----------------------------------------
//   command   | start / busy       | cmd_i, cell_x_i, cell_y_i, cell_value_i
//   result    | done_o strobe      | frontier_count_o
//   config    | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// a write command leaves busy low.
// a query raises busy while it scans the S*S cells of its window, S the
// clamped window size, and shows its count with done_o as busy drops; the
// two-port grid ram gives two reads a cycle and each window cell needs five.
// reset clears control and presets config; grid contents stay undefined.
// the receiver cannot stall: the result is valid for one cycle only.
`default_nettype none

module frontier_window_counter
  import fwc_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // command word
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     cmd_i,
  input  wire logic [7:0]               cell_x_i,
  input  wire logic [7:0]               cell_y_i,
  input  wire logic signed [CELL_W-1:0] cell_value_i,
  // result word
  output logic                          done_o,
  output logic [CNT_W-1:0]              frontier_count_o,
  // config write port
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic signed [CRD_W-1:0] MAX_W_C   = CRD_W'(MAX_WIDTH);
  localparam logic signed [CRD_W-1:0] MAX_H_C   = CRD_W'(MAX_HEIGHT);
  localparam logic signed [CRD_W-1:0] MAX_WIN_C = CRD_W'(MAX_WINDOW);
  localparam logic signed [CRD_W-1:0] MIN_C     = CRD_W'(GRID_MIN);
  localparam logic signed [CRD_W-1:0] ONE_C     = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] TWO_C     = CRD_W'(2);

  // controller states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // read phases of one window cell
  localparam logic [1:0] PH_CU = 2'd0;  // centre and up
  localparam logic [1:0] PH_DL = 2'd1;  // down and left
  localparam logic [1:0] PH_R  = 2'd2;  // right

  // grid cell address from coordinates
  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CRD_W-1:0] ax,
                                                  input logic signed [CRD_W-1:0] ay);
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    row = ADDR_W'($unsigned(ay));
    col = ADDR_W'($unsigned(ax));
    return ADDR_W'(row * ADDR_W'(MAX_WIDTH)) + col;
  endfunction

  // config registers
  logic [CFG_W-1:0]     gw_q;
  logic [CFG_W-1:0]     gh_q;
  logic [WIN_REG_W-1:0] ws_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= CFG_W'(256);
      gh_q <= CFG_W'(256);
      ws_q <= WIN_REG_W'(18);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  gw_q <= cfg_data_i;
        REG_GRID_HEIGHT: gh_q <= cfg_data_i;
        REG_WINDOW_SIZE: ws_q <= cfg_data_i[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped grid and window sizes
  logic signed [CRD_W-1:0] gw_ext, gh_ext, ws_ext;
  logic signed [CRD_W-1:0] gw_eff, gh_eff, ws_eff;
  logic signed [CRD_W-1:0] half_lo, half_hi;
  logic signed [CRD_W-1:0] x_in, y_in;

  always_comb begin
    gw_ext = {{(CRD_W-CFG_W){1'b0}}, gw_q};
    gh_ext = {{(CRD_W-CFG_W){1'b0}}, gh_q};
    ws_ext = {{(CRD_W-WIN_REG_W){1'b0}}, ws_q};
    gw_eff = (gw_ext < MIN_C) ? MIN_C : ((gw_ext > MAX_W_C) ? MAX_W_C : gw_ext);
    gh_eff = (gh_ext < MIN_C) ? MIN_C : ((gh_ext > MAX_H_C) ? MAX_H_C : gh_ext);
    ws_eff = (ws_ext < ONE_C) ? ONE_C : ((ws_ext > MAX_WIN_C) ? MAX_WIN_C : ws_ext);
    half_lo = ws_eff >>> 1;
    half_hi = ws_eff - half_lo - ONE_C;
    x_in = {{(CRD_W-8){1'b0}}, cell_x_i};
    y_in = {{(CRD_W-8){1'b0}}, cell_y_i};
  end

  // command accept
  logic accept, wr_go, qry_go;

  assign accept = start && !busy;
  assign wr_go  = accept && (cmd_i == CMD_WRITE) && (x_in < gw_eff) && (y_in < gh_eff);
  assign qry_go = accept && (cmd_i == CMD_QUERY);

  // scan controller
  logic [1:0]              state_q, state_d;
  logic [1:0]              ph_q;
  logic signed [CRD_W-1:0] cx_q, cy_q;
  logic signed [CRD_W-1:0] x_lo_q, x_hi_q, y_hi_q;
  logic signed [CRD_W-1:0] x_lim_q, y_lim_q;
  logic                    cell_end, scan_end;

  assign busy     = (state_q != ST_IDLE);
  assign cell_end = (ph_q == PH_R);
  assign scan_end = cell_end && (cx_q == x_hi_q) && (cy_q == y_hi_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (qry_go) state_d = ST_SCAN;
      ST_SCAN:  if (scan_end) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_CU;
    end else begin
      state_q <= state_d;
      if (qry_go || cell_end) begin
        ph_q <= PH_CU;
      end else if (state_q == ST_SCAN) begin
        ph_q <= ph_q + 2'd1;
      end
    end
  end

  // window bounds and cell counters
  always_ff @(posedge clk_i) begin
    if (qry_go) begin
      x_lo_q  <= x_in - half_lo;
      x_hi_q  <= x_in + half_hi;
      y_hi_q  <= y_in + half_hi;
      x_lim_q <= gw_eff - TWO_C;
      y_lim_q <= gh_eff - TWO_C;
      cx_q    <= x_in - half_lo;
      cy_q    <= y_in - half_lo;
    end else if (state_q == ST_SCAN && cell_end) begin
      if (cx_q == x_hi_q) begin
        cx_q <= x_lo_q;
        cy_q <= cy_q + ONE_C;
      end else begin
        cx_q <= cx_q + ONE_C;
      end
    end
  end

  // read address generation
  logic              interior;
  logic [ADDR_W-1:0] raddr_a, raddr_b;

  assign interior = (cx_q >= ONE_C) && (cx_q <= x_lim_q) &&
                    (cy_q >= ONE_C) && (cy_q <= y_lim_q);

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (interior) begin
      unique case (ph_q)
        PH_CU: begin
          raddr_a = cell_addr(cx_q, cy_q);
          raddr_b = cell_addr(cx_q, cy_q - ONE_C);
        end
        PH_DL: begin
          raddr_a = cell_addr(cx_q, cy_q + ONE_C);
          raddr_b = cell_addr(cx_q - ONE_C, cy_q);
        end
        PH_R: begin
          raddr_a = cell_addr(cx_q + ONE_C, cy_q);
          raddr_b = cell_addr(cx_q + ONE_C, cy_q);
        end
        default: ;
      endcase
    end
  end

  // grid memory
  logic [CELL_W-1:0] rdata_a, rdata_b;

  fwc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i     (clk_i),
    .we_i      (wr_go),
    .waddr_i   (cell_addr(x_in, y_in)),
    .wdata_i   ($unsigned(cell_value_i)),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // read data stage tags
  logic       s1_vld_q;
  logic [1:0] s1_ph_q;
  logic       s1_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s1_ph_q  <= PH_CU;
      s1_int_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == ST_SCAN);
      s1_ph_q  <= ph_q;
      s1_int_q <= interior;
    end
  end

  // frontier test and count
  logic             ctr_ok_q, ctr_ok_d;
  logic             unk_q, unk_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             a_unk, b_unk;

  assign a_unk = (rdata_a == UNKNOWN_CELL);
  assign b_unk = (rdata_b == UNKNOWN_CELL);

  always_comb begin
    ctr_ok_d = ctr_ok_q;
    unk_d    = unk_q;
    cnt_d    = cnt_q;
    if (s1_vld_q) begin
      unique case (s1_ph_q)
        PH_CU: begin
          ctr_ok_d = s1_int_q && (rdata_a <= FREE_LIMIT);
          unk_d    = b_unk;
        end
        PH_DL: begin
          unk_d = unk_q || a_unk || b_unk;
        end
        PH_R: begin
          if (ctr_ok_q && (unk_q || a_unk) && (cnt_q != CNT_MAX)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_ok_q <= 1'b0;
      unk_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      ctr_ok_q <= ctr_ok_d;
      unk_q    <= unk_d;
      cnt_q    <= qry_go ? '0 : cnt_d;
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == ST_DRAIN);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      frontier_count_o <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fwc_checker.sv
// fwc_checker: port level checks of the frontier window counter
// depends on fwc_pkg; bound to the top level at the end of this file
`default_nettype none

module fwc_checker
  import fwc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic cmd_i,
  input wire logic done_o
);

  logic accept;
  assign accept = start && !busy;

  // a write never makes the block busy
  a_write_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CMD_WRITE) |=> !busy)
    else $error("write command raised busy");

  // a query always makes the block busy
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CMD_QUERY) |=> busy)
    else $error("query did not raise busy");

  // the result word comes exactly when busy drops
  a_done_on_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // a result only appears after a query ends
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result word without a finished query");

endmodule

bind frontier_window_counter fwc_checker u_fwc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .cmd_i  (cmd_i),
  .done_o (done_o)
);

`default_nettype wire

### tb/testbench.sv
// testbench for frontier_window_counter: directed and random cell writes and queries,
// every count predicted by an in-bench grid model and compared as it arrives
// depends on fwc_pkg and the frontier_window_counter rtl
`timescale 1ns / 1ps

module testbench;
  import fwc_pkg::*;

  localparam int GRID_SIDE  = 256;
  localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int WIN_MAX    = 64;

  // grid model, pending counts and checking
  class frontier_tally;
    logic [CELL_W-1:0]    cells [0:GRID_CELLS-1];
    bit                   seen  [0:GRID_CELLS-1];
    logic [CFG_W-1:0]     width_reg;
    logic [CFG_W-1:0]     height_reg;
    logic [WIN_REG_W-1:0] win_reg;
    logic [CNT_W-1:0]     counts_due [$];
    int unsigned          failures;
    int unsigned          queries;
    int unsigned          writes;
    int unsigned          checked;

    function new();
      width_reg  = 9'd256;
      height_reg = 9'd256;
      win_reg    = 7'd18;
      failures   = 0;
      queries    = 0;
      writes     = 0;
      checked    = 0;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int eff_width();
      return clamp(width_reg, GRID_MIN, GRID_SIDE);
    endfunction

    function int eff_height();
      return clamp(height_reg, GRID_MIN, GRID_SIDE);
    endfunction

    function int eff_window();
      return clamp(win_reg, 1, WIN_MAX);
    endfunction

    function int cell_index(int x, int y);
      return y * GRID_SIDE + x;
    endfunction

    function bit is_unknown(int x, int y);
      return cells[cell_index(x, y)] == UNKNOWN_CELL;
    endfunction

    // frontier cells of the window around (qx, qy), interior cells only
    function logic [CNT_W-1:0] count_frontier(int qx, int qy);
      int gw, gh, ws, lo, hi, cx, cy;
      logic [CNT_W-1:0] n;
      gw = eff_width();
      gh = eff_height();
      ws = eff_window();
      lo = ws / 2;
      hi = ws - lo - 1;
      n  = '0;
      for (cy = qy - lo; cy <= qy + hi; cy++) begin
        for (cx = qx - lo; cx <= qx + hi; cx++) begin
          if (cy > 0 && cy < gh - 1 && cx > 0 && cx < gw - 1 &&
              cells[cell_index(cx, cy)] <= FREE_LIMIT &&
              (is_unknown(cx, cy + 1) || is_unknown(cx, cy - 1) ||
               is_unknown(cx - 1, cy) || is_unknown(cx + 1, cy))) begin
            if (n < CNT_MAX) n++;
          end
        end
      end
      return n;
    endfunction

    function void note_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH: begin
          width_reg = data;
        end
        REG_GRID_HEIGHT: begin
          height_reg = data;
        end
        REG_WINDOW_SIZE: begin
          win_reg = data[WIN_REG_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // accepted command word: store the cell or queue the predicted count
    function void note_word(logic cmd, logic [7:0] x, logic [7:0] y, logic [7:0] value);
      if (cmd == CMD_WRITE) begin
        writes++;
        if (x < eff_width() && y < eff_height()) begin
          cells[cell_index(x, y)] = value;
          seen[cell_index(x, y)]  = 1'b1;
        end
      end else begin
        queries++;
        counts_due = {counts_due, count_frontier(x, y)};
      end
    endfunction

    function void check_count(logic [CNT_W-1:0] got);
      logic [CNT_W-1:0] want;
      if (counts_due.size() == 0) begin
        failures++;
        $display("%0t: count word with no query waiting, expected none, actual %0d",
                 $time, got);
      end else begin
        want = counts_due.pop_front();
        checked++;
        if (got !== want) begin
          failures++;
          $display("%0t: frontier_count mismatch, expected %0d, actual %0d",
                   $time, want, got);
        end
      end
    endfunction

    function int pending();
      return counts_due.size();
    endfunction
  endclass

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic                     cmd_i        = CMD_WRITE;
  logic [7:0]               cell_x_i     = 8'd0;
  logic [7:0]               cell_y_i     = 8'd0;
  logic signed [CELL_W-1:0] cell_value_i = 8'sd0;
  logic                     done_o;
  logic [CNT_W-1:0]         frontier_count_o;
  logic                     cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i    = REG_GRID_WIDTH;
  logic [CFG_W-1:0]         cfg_data_i   = '0;

  frontier_tally tally;
  bit            steady;
  int unsigned   burst_left;
  int unsigned   settings;

  frontier_window_counter u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .cell_value_i     (cell_value_i),
    .done_o           (done_o),
    .frontier_count_o (frontier_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // result word monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tally.check_count(frontier_count_o);
  end

  // run limit
  initial begin
    #150_000_000;
    $display("simulation failed");
    $finish;
  end

  // cell values weighted toward unknown and free so frontiers are common
  function automatic logic [7:0] pick_cell();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return UNKNOWN_CELL;
    else if (r < 65) return 8'($urandom_range(0, 15));
    else if (r < 85) return 8'($urandom_range(16, 100));
    return 8'($urandom);
  endfunction

  // sender bursts with random gaps, skipped in steady stretches
  task automatic pace();
    if (!steady) begin
      if (burst_left == 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // present one command word and hold it until accepted; called at a falling edge
  task automatic send_word(logic c, logic [7:0] x, logic [7:0] y, logic [7:0] v);
    start        = 1'b1;
    cmd_i        = c;
    cell_x_i     = x;
    cell_y_i     = y;
    cell_value_i = v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    tally.note_word(c, x, y, v);
    @(negedge clk_i);
    pace();
  endtask

  // stop sending and wait until every count has come back
  task automatic settle(int tail);
    start = 1'b0;
    while (tally.pending() > 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // three register writes on consecutive cycles, block idle
  task automatic set_config(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] win);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = REG_GRID_WIDTH;
    cfg_data_i = w;
    @(posedge clk_i);
    tally.note_reg(REG_GRID_WIDTH, w);
    @(negedge clk_i);
    cfg_idx_i  = REG_GRID_HEIGHT;
    cfg_data_i = h;
    @(posedge clk_i);
    tally.note_reg(REG_GRID_HEIGHT, h);
    @(negedge clk_i);
    cfg_idx_i  = REG_WINDOW_SIZE;
    cfg_data_i = win;
    @(posedge clk_i);
    tally.note_reg(REG_WINDOW_SIZE, win);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    settings++;
  endtask

  // write every unwritten cell the query may touch, then send the query
  task automatic fill_and_query(int qx, int qy);
    int gw, gh, ws, lo, hi, cx, cy;
    gw = tally.eff_width();
    gh = tally.eff_height();
    ws = tally.eff_window();
    lo = ws / 2;
    hi = ws - lo - 1;
    for (cy = qy - lo - 1; cy <= qy + hi + 1; cy++) begin
      for (cx = qx - lo - 1; cx <= qx + hi + 1; cx++) begin
        if (cy >= 0 && cy < gh && cx >= 0 && cx < gw &&
            !tally.seen[tally.cell_index(cx, cy)]) begin
          send_word(CMD_WRITE, cx[7:0], cy[7:0], pick_cell());
        end
      end
    end
    send_word(CMD_QUERY, qx[7:0], qy[7:0], 8'($urandom));
  endtask

  // one grid setting with a random mix of writes and queries
  task automatic random_phase(int w, int h, int win, int items, bit gapless);
    int n, r, gw, gh;
    settle(4);
    set_config(w[CFG_W-1:0], h[CFG_W-1:0], win[CFG_W-1:0]);
    steady     = gapless;
    burst_left = 0;
    gw = tally.eff_width();
    gh = tally.eff_height();
    for (n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_word(CMD_WRITE, 8'($urandom_range(0, gw - 1)),
                  8'($urandom_range(0, gh - 1)), pick_cell());
      end else if (r < 65) begin
        send_word(CMD_WRITE, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 85) begin
        fill_and_query($urandom_range(0, gw - 1), $urandom_range(0, gh - 1));
      end else begin
        fill_and_query($urandom_range(0, 255), $urandom_range(0, 255));
      end
      // hold off mid phase until the block has drained
      if (items > 10 && n == items / 2) settle(0);
    end
  endtask

  // main sequence
  initial begin
    tally      = new();
    steady     = 1'b1;
    burst_left = 0;
    settings   = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // smallest grid and window, both reached by clamping
    set_config(9'd0, 9'd2, 9'd0);
    send_word(CMD_WRITE, 8'd0, 8'd0, -8'sd128);
    send_word(CMD_WRITE, 8'd1, 8'd0, UNKNOWN_CELL);
    send_word(CMD_WRITE, 8'd2, 8'd0, 8'sd127);
    send_word(CMD_WRITE, 8'd0, 8'd1, 8'd100);
    send_word(CMD_WRITE, 8'd1, 8'd1, FREE_LIMIT);
    send_word(CMD_WRITE, 8'd2, 8'd1, 8'd16);
    send_word(CMD_WRITE, 8'd0, 8'd2, 8'd0);
    send_word(CMD_WRITE, 8'd1, 8'd2, UNKNOWN_CELL);
    send_word(CMD_WRITE, 8'd2, 8'd2, UNKNOWN_CELL);
    // writes outside the grid in use are dropped
    send_word(CMD_WRITE, 8'd255, 8'd255, 8'd5);
    send_word(CMD_WRITE, 8'd3, 8'd1, 8'd0);
    // free cell next to unknown, border cell, centre off the grid
    send_word(CMD_QUERY, 8'd1, 8'd1, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd0, 8'd0);
    send_word(CMD_QUERY, 8'd255, 8'd0, 8'hFF);
    send_word(CMD_WRITE, 8'd1, 8'd1, 8'd0);
    send_word(CMD_QUERY, 8'd1, 8'd1, 8'd0);
    send_word(CMD_WRITE, 8'd1, 8'd1, 8'd16);
    send_word(CMD_QUERY, 8'd1, 8'd1, 8'd0);

    // window clamped to its largest size, running past the grid
    settle(4);
    set_config(9'd0, 9'd2, 9'd127);
    send_word(CMD_WRITE, 8'd1, 8'd1, 8'd7);
    send_word(CMD_QUERY, 8'd0, 8'd0, 8'd0);
    send_word(CMD_QUERY, 8'd255, 8'd255, 8'd0);

    // grid registers above the largest grid clamp to it, far corner in use
    settle(4);
    set_config(9'd511, 9'd257, 9'h081);
    send_word(CMD_WRITE, 8'd255, 8'd254, UNKNOWN_CELL);
    send_word(CMD_WRITE, 8'd254, 8'd254, 8'd3);
    fill_and_query(254, 254);

    // random phases on small grids; the window register also sees data above its width
    random_phase(6, 5, 'h105, 14, 1'b0);
    random_phase(10, 3, 64, 8, 1'b1);
    random_phase(5, 9, 3, 12, 1'b0);
    random_phase(7, 7, 2, 12, 1'b0);
    random_phase(9, 4, 8, 10, 1'b1);

    settle(16);
    $display("ran %0d queries and %0d cell writes over %0d grid settings",
             tally.queries, tally.writes, settings);
    $display("%0d counts compared, %0d mismatches", tally.checked, tally.failures);
    if (tally.failures == 0 && tally.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
